>>> hdl/ifmt_pkg.sv
`timescale 1ns / 1ps

package ifmt_pkg;

  // Field widths
  localparam int ValueW = 32;
  localparam int CmdW   = 2;
  localparam int CharW  = 8;
  localparam int CntW   = 5;
  localparam int UpcW   = 4;
  localparam int BcdDig = 10;
  localparam int BcdW   = 4 * BcdDig;

  typedef logic [UpcW-1:0]  upc_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [CharW-1:0] char_t;

  // Format modes
  localparam logic [CmdW-1:0] MODE_RAW = 2'd0;
  localparam logic [CmdW-1:0] MODE_BIN = 2'd1;
  localparam logic [CmdW-1:0] MODE_HEX = 2'd2;
  localparam logic [CmdW-1:0] MODE_DEC = 2'd3;

  // ASCII codes
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_B      = 8'h62;
  localparam char_t CH_X      = 8'h78;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_HEXOFS = 8'h37;  // 'A' - 10

  // Microprogram addresses
  localparam upc_t UA_IDLE = 4'd0;
  localparam upc_t UA_RAW  = 4'd1;
  localparam upc_t UA_B0   = 4'd2;
  localparam upc_t UA_B1   = 4'd3;
  localparam upc_t UA_BSP  = 4'd4;
  localparam upc_t UA_BBIT = 4'd5;
  localparam upc_t UA_H0   = 4'd6;
  localparam upc_t UA_H1   = 4'd7;
  localparam upc_t UA_HDIG = 4'd8;
  localparam upc_t UA_DDAB = 4'd9;
  localparam upc_t UA_DSET = 4'd10;
  localparam upc_t UA_DDIG = 4'd11;

  localparam cnt_t CNT_BITS = 5'd31;
  localparam cnt_t CNT_HEX  = 5'd7;
  localparam cnt_t CNT_DEC  = 5'd9;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_ALWAYS,
    EM_DIGIT     // decimal digit, leading zeros suppressed
  } emit_e_t;

  typedef enum logic [2:0] {
    CS_ZERO,
    CS_B,
    CS_X,
    CS_SPACE,
    CS_BIT,
    CS_HEX,
    CS_DEC,
    CS_RAW
  } chsel_e_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SH1,
    OP_SH4,
    OP_DABBLE,
    OP_BCDSH
  } dpop_e_t;

  typedef enum logic [1:0] {
    CO_HOLD,
    CO_DEC,
    CO_LOAD
  } cntop_e_t;

  typedef enum logic [1:0] {
    EN_NONE,
    EN_ALWAYS,
    EN_CNT0
  } endc_e_t;

  typedef enum logic [2:0] {
    J_SEQ,   // next address
    J_GO,    // unconditional to target
    J_MODE,  // dispatch on command
    J_NZ,    // target while count nonzero, else next
    J_NIB    // target on a group boundary, else stay
  } jmp_e_t;

  typedef struct packed {
    logic     take;
    emit_e_t  emit;
    chsel_e_t chsel;
    dpop_e_t  op;
    cntop_e_t cnt_op;
    cnt_t     cnt_ld;
    endc_e_t  endc;
    jmp_e_t   jmp;
    upc_t     target;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic emit_req;
    logic slot_free;
    logic cnt_zero;
    logic cnt_grp;
  } dp_stat_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic step;
    logic last;
  } seq_cmd_t;

  function automatic ctrl_t mk(logic take, emit_e_t emit, chsel_e_t chsel, dpop_e_t op,
                               cntop_e_t cnt_op, cnt_t cnt_ld, endc_e_t endc,
                               jmp_e_t jmp, upc_t target);
    ctrl_t c;
    c.take   = take;
    c.emit   = emit;
    c.chsel  = chsel;
    c.op     = op;
    c.cnt_op = cnt_op;
    c.cnt_ld = cnt_ld;
    c.endc   = endc;
    c.jmp    = jmp;
    c.target = target;
    return c;
  endfunction

  function automatic upc_t mode_entry(logic [CmdW-1:0] cmd);
    upc_t a;
    unique case (cmd)
      MODE_RAW: a = UA_RAW;
      MODE_BIN: a = UA_B0;
      MODE_HEX: a = UA_H0;
      MODE_DEC: a = UA_DDAB;
    endcase
    return a;
  endfunction

  // One double-dabble step: add 3 to digits of 5 or more, then shift in a bit
  function automatic logic [BcdW-1:0] dabble(logic [BcdW-1:0] bcd, logic bit_in);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int d = 0; d < BcdDig; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BcdW-2:0], bit_in};
  endfunction

endpackage

>>> hdl/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps

// Channel   Ports                                   Direction
// in        in_valid, in_ready, in_value, in_command  into block
// out       out_valid, out_ready, out_char_code,      out of block
//           out_last_char
//
// The idle step takes an item, then one microprogram step per cycle unless a step
// holds; no new item is taken until the run ends. Decimal runs 32 double-dabble
// steps, one setup step, then ten digit steps with leading zeros skipped.
// The step rate is set by the single sequencer and its one output register.
// Synchronous active-low reset returns the sequencer to idle and empties the output.
// A step that emits holds while the output register is full and not being drained.
module integer_to_ascii_formatter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ifmt_pkg::ValueW-1:0]     in_value,
  input  logic [ifmt_pkg::CmdW-1:0]       in_command,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ifmt_pkg::CharW-1:0]      out_char_code,
  output logic                            out_last_char
);

  ifmt_pkg::upc_t     upc;
  ifmt_pkg::ctrl_t    ctrl;
  ifmt_pkg::dp_stat_t stat;
  ifmt_pkg::seq_cmd_t cmd;

  ifmt_rom u_rom (
    .upc  (upc),
    .ctrl (ctrl)
  );

  ifmt_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .ctrl       (ctrl),
    .stat       (stat),
    .upc        (upc),
    .cmd        (cmd)
  );

  ifmt_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .ctrl          (ctrl),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  // only the dispatch word takes input
  assign in_ready = ctrl.take;

endmodule

>>> hdl/ifmt_rom.sv
`timescale 1ns / 1ps

// Control store: one control word per microprogram address
module ifmt_rom (
  input  ifmt_pkg::upc_t  upc,
  output ifmt_pkg::ctrl_t ctrl
);

  always_comb begin
    unique case (upc)
      // wait for an input transfer, load datapath, dispatch on mode
      ifmt_pkg::UA_IDLE: ctrl = ifmt_pkg::mk(1'b1, ifmt_pkg::EM_NONE, ifmt_pkg::CS_ZERO,
          ifmt_pkg::OP_LOAD, ifmt_pkg::CO_LOAD, ifmt_pkg::CNT_BITS, ifmt_pkg::EN_NONE,
          ifmt_pkg::J_MODE, ifmt_pkg::UA_IDLE);
      // raw byte
      ifmt_pkg::UA_RAW: ctrl = ifmt_pkg::mk(1'b0, ifmt_pkg::EM_ALWAYS, ifmt_pkg::CS_RAW,
          ifmt_pkg::OP_NOP, ifmt_pkg::CO_HOLD, '0, ifmt_pkg::EN_ALWAYS,
          ifmt_pkg::J_SEQ, ifmt_pkg::UA_IDLE);
      // binary: "0b", then a space before each group of four bits
      ifmt_pkg::UA_B0: ctrl = ifmt_pkg::mk(1'b0, ifmt_pkg::EM_ALWAYS, ifmt_pkg::CS_ZERO,
          ifmt_pkg::OP_NOP, ifmt_pkg::CO_HOLD, '0, ifmt_pkg::EN_NONE,
          ifmt_pkg::J_SEQ, ifmt_pkg::UA_IDLE);
      ifmt_pkg::UA_B1: ctrl = ifmt_pkg::mk(1'b0, ifmt_pkg::EM_ALWAYS, ifmt_pkg::CS_B,
          ifmt_pkg::OP_NOP, ifmt_pkg::CO_HOLD, '0, ifmt_pkg::EN_NONE,
          ifmt_pkg::J_SEQ, ifmt_pkg::UA_IDLE);
      ifmt_pkg::UA_BSP: ctrl = ifmt_pkg::mk(1'b0, ifmt_pkg::EM_ALWAYS, ifmt_pkg::CS_SPACE,
          ifmt_pkg::OP_NOP, ifmt_pkg::CO_HOLD, '0, ifmt_pkg::EN_NONE,
          ifmt_pkg::J_SEQ, ifmt_pkg::UA_IDLE);
      ifmt_pkg::UA_BBIT: ctrl = ifmt_pkg::mk(1'b0, ifmt_pkg::EM_ALWAYS, ifmt_pkg::CS_BIT,
          ifmt_pkg::OP_SH1, ifmt_pkg::CO_DEC, '0, ifmt_pkg::EN_CNT0,
          ifmt_pkg::J_NIB, ifmt_pkg::UA_BSP);
      // hex: "0x" and eight digits
      ifmt_pkg::UA_H0: ctrl = ifmt_pkg::mk(1'b0, ifmt_pkg::EM_ALWAYS, ifmt_pkg::CS_ZERO,
          ifmt_pkg::OP_NOP, ifmt_pkg::CO_HOLD, '0, ifmt_pkg::EN_NONE,
          ifmt_pkg::J_SEQ, ifmt_pkg::UA_IDLE);
      ifmt_pkg::UA_H1: ctrl = ifmt_pkg::mk(1'b0, ifmt_pkg::EM_ALWAYS, ifmt_pkg::CS_X,
          ifmt_pkg::OP_NOP, ifmt_pkg::CO_LOAD, ifmt_pkg::CNT_HEX, ifmt_pkg::EN_NONE,
          ifmt_pkg::J_SEQ, ifmt_pkg::UA_IDLE);
      ifmt_pkg::UA_HDIG: ctrl = ifmt_pkg::mk(1'b0, ifmt_pkg::EM_ALWAYS, ifmt_pkg::CS_HEX,
          ifmt_pkg::OP_SH4, ifmt_pkg::CO_DEC, '0, ifmt_pkg::EN_CNT0,
          ifmt_pkg::J_GO, ifmt_pkg::UA_HDIG);
      // decimal: 32 double-dabble steps, then ten digits
      ifmt_pkg::UA_DDAB: ctrl = ifmt_pkg::mk(1'b0, ifmt_pkg::EM_NONE, ifmt_pkg::CS_ZERO,
          ifmt_pkg::OP_DABBLE, ifmt_pkg::CO_DEC, '0, ifmt_pkg::EN_NONE,
          ifmt_pkg::J_NZ, ifmt_pkg::UA_DDAB);
      ifmt_pkg::UA_DSET: ctrl = ifmt_pkg::mk(1'b0, ifmt_pkg::EM_NONE, ifmt_pkg::CS_ZERO,
          ifmt_pkg::OP_NOP, ifmt_pkg::CO_LOAD, ifmt_pkg::CNT_DEC, ifmt_pkg::EN_NONE,
          ifmt_pkg::J_SEQ, ifmt_pkg::UA_IDLE);
      ifmt_pkg::UA_DDIG: ctrl = ifmt_pkg::mk(1'b0, ifmt_pkg::EM_DIGIT, ifmt_pkg::CS_DEC,
          ifmt_pkg::OP_BCDSH, ifmt_pkg::CO_DEC, '0, ifmt_pkg::EN_CNT0,
          ifmt_pkg::J_GO, ifmt_pkg::UA_DDIG);
      // unused addresses fall back to idle
      default: ctrl = ifmt_pkg::mk(1'b0, ifmt_pkg::EM_NONE, ifmt_pkg::CS_ZERO,
          ifmt_pkg::OP_NOP, ifmt_pkg::CO_HOLD, '0, ifmt_pkg::EN_ALWAYS,
          ifmt_pkg::J_SEQ, ifmt_pkg::UA_IDLE);
    endcase
  end

endmodule

>>> hdl/ifmt_seq.sv
`timescale 1ns / 1ps

// Microprogram counter and branch logic
module ifmt_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [ifmt_pkg::CmdW-1:0]     in_command,
  input  ifmt_pkg::ctrl_t               ctrl,
  input  ifmt_pkg::dp_stat_t            stat,
  output ifmt_pkg::upc_t                upc,
  output ifmt_pkg::seq_cmd_t            cmd
);

  ifmt_pkg::upc_t upc_r, upc_nxt;
  logic           adv;
  logic           end_now;

  // a step holds while waiting for input or for a free output slot
  assign adv = ctrl.take ? in_valid : !(stat.emit_req && !stat.slot_free);

  always_comb begin
    unique case (ctrl.endc)
      ifmt_pkg::EN_ALWAYS: end_now = 1'b1;
      ifmt_pkg::EN_CNT0:   end_now = stat.cnt_zero;
      default:             end_now = 1'b0;
    endcase
  end

  // next address
  always_comb begin
    upc_nxt = upc_r;
    if (adv) begin
      if (end_now) begin
        upc_nxt = ifmt_pkg::UA_IDLE;
      end else begin
        unique case (ctrl.jmp)
          ifmt_pkg::J_SEQ:  upc_nxt = upc_r + 1'b1;
          ifmt_pkg::J_GO:   upc_nxt = ctrl.target;
          ifmt_pkg::J_MODE: upc_nxt = ifmt_pkg::mode_entry(in_command);
          ifmt_pkg::J_NZ:   upc_nxt = stat.cnt_zero ? upc_r + 1'b1 : ctrl.target;
          ifmt_pkg::J_NIB:  upc_nxt = stat.cnt_grp ? ctrl.target : upc_r;
          default:          upc_nxt = ifmt_pkg::UA_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ifmt_pkg::UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign upc      = upc_r;
  assign cmd.step = adv;
  assign cmd.last = end_now;

  // a finished run always returns to idle
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && end_now) |=> (upc_r == ifmt_pkg::UA_IDLE))
    else $error("run end did not return to idle");

  // a step blocked on a full output slot keeps its address
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.emit_req && !stat.slot_free && !ctrl.take) |=> $stable(upc_r))
    else $error("address moved during output stall");

  // the program never wanders past its last word
  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r <= ifmt_pkg::UA_DDIG)
    else $error("microprogram counter out of range");

endmodule

>>> hdl/ifmt_dp.sv
`timescale 1ns / 1ps

// Datapath: value shifter, BCD register, loop counter, character build, output register
module ifmt_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [ifmt_pkg::ValueW-1:0]     in_value,
  input  ifmt_pkg::ctrl_t                 ctrl,
  input  ifmt_pkg::seq_cmd_t              cmd,
  output ifmt_pkg::dp_stat_t              stat,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [ifmt_pkg::CharW-1:0]      out_char_code,
  output logic                            out_last_char
);

  logic [ifmt_pkg::ValueW-1:0] sh_r;
  logic [ifmt_pkg::BcdW-1:0]   bcd_r;
  ifmt_pkg::cnt_t              cnt_r;
  logic                        started_r;
  logic                        out_valid_r;
  ifmt_pkg::char_t             out_char_r;
  logic                        out_last_r;

  logic [3:0]      dec_dig;
  logic [3:0]      hex_dig;
  ifmt_pkg::char_t ch;
  logic            emit_req;

  assign dec_dig = bcd_r[ifmt_pkg::BcdW-1 -: 4];
  assign hex_dig = sh_r[ifmt_pkg::ValueW-1 -: 4];

  // emit decision; leading decimal zeros are skipped but the units digit always goes
  always_comb begin
    unique case (ctrl.emit)
      ifmt_pkg::EM_ALWAYS: emit_req = 1'b1;
      ifmt_pkg::EM_DIGIT:  emit_req = started_r || (dec_dig != 4'd0) || (cnt_r == '0);
      default:             emit_req = 1'b0;
    endcase
  end

  // character select
  always_comb begin
    unique case (ctrl.chsel)
      ifmt_pkg::CS_ZERO:  ch = ifmt_pkg::CH_ZERO;
      ifmt_pkg::CS_B:     ch = ifmt_pkg::CH_B;
      ifmt_pkg::CS_X:     ch = ifmt_pkg::CH_X;
      ifmt_pkg::CS_SPACE: ch = ifmt_pkg::CH_SPACE;
      ifmt_pkg::CS_BIT:   ch = ifmt_pkg::CH_ZERO + {7'd0, sh_r[ifmt_pkg::ValueW-1]};
      ifmt_pkg::CS_HEX:   ch = (hex_dig < 4'd10) ? ifmt_pkg::CH_ZERO + {4'd0, hex_dig}
                                                 : ifmt_pkg::CH_HEXOFS + {4'd0, hex_dig};
      ifmt_pkg::CS_DEC:   ch = ifmt_pkg::CH_ZERO + {4'd0, dec_dig};
      ifmt_pkg::CS_RAW:   ch = sh_r[ifmt_pkg::CharW-1:0];
    endcase
  end

  assign stat.emit_req  = emit_req;
  assign stat.slot_free = !out_valid_r || out_ready;
  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.cnt_grp   = (cnt_r[1:0] == 2'd0);

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      unique case (ctrl.op)
        ifmt_pkg::OP_LOAD: begin
          sh_r  <= in_value;
          bcd_r <= '0;
        end
        ifmt_pkg::OP_SH1:    sh_r <= {sh_r[ifmt_pkg::ValueW-2:0], 1'b0};
        ifmt_pkg::OP_SH4:    sh_r <= {sh_r[ifmt_pkg::ValueW-5:0], 4'd0};
        ifmt_pkg::OP_DABBLE: begin
          bcd_r <= ifmt_pkg::dabble(bcd_r, sh_r[ifmt_pkg::ValueW-1]);
          sh_r  <= {sh_r[ifmt_pkg::ValueW-2:0], 1'b0};
        end
        ifmt_pkg::OP_BCDSH:  bcd_r <= {bcd_r[ifmt_pkg::BcdW-5:0], 4'd0};
        default: ;
      endcase
    end
  end

  // loop counter and leading-zero flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      started_r <= 1'b0;
    end else if (cmd.step) begin
      unique case (ctrl.cnt_op)
        ifmt_pkg::CO_LOAD: cnt_r <= ctrl.cnt_ld;
        ifmt_pkg::CO_DEC:  cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
      if (ctrl.op == ifmt_pkg::OP_LOAD) begin
        started_r <= 1'b0;
      end else if (ctrl.emit == ifmt_pkg::EM_DIGIT && emit_req) begin
        started_r <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step && emit_req) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit_req) begin
      out_char_r <= ch;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

  // a new character is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(cmd.step && emit_req))
    else $error("output slot overwritten");

endmodule

>>> bench/integer_to_ascii_formatter_tb.sv
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;

  localparam int    RESET_CYCLES = 7;
  localparam int    HOLD_CYCLES  = 600;   // long receiver stall for the backpressure test
  localparam int    SETTLE_CYCLES = 60;   // a little more than the slowest run (decimal)
  localparam int    CYCLE_LIMIT  = 500000;
  localparam ifmt_pkg::char_t CH_UPPER_A = 8'h41;
  localparam ifmt_pkg::char_t CH_ONE     = 8'h31;

  // One character of a formatted run
  typedef struct {
    ifmt_pkg::char_t code;
    logic            last;
  } char_beat_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [ifmt_pkg::ValueW-1:0]   in_value = '0;
  logic [ifmt_pkg::CmdW-1:0]     in_command = ifmt_pkg::MODE_RAW;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [ifmt_pkg::CharW-1:0]    out_char_code;
  logic                          out_last_char;

  char_beat_t expected_chars[$];
  int         err_count = 0;
  int         chars_checked = 0;
  int         runs_checked = 0;
  int         mode_count[4] = '{0, 0, 0, 0};
  int         send_gap_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_left = 0;
  logic       hold_req = 1'b0;
  int         cycle_count = 0;

  integer_to_ascii_formatter u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_command   (in_command),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still expected",
               cycle_count, expected_chars.size());
      $display("integer_to_ascii_formatter_tb: FAIL");
      $finish;
    end
  end

  // Long receiver hold-off, counted here, started on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // Receiver ready
  always @(posedge clk) begin
    if (!rst_n || hold_left != 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: every transfer against the oldest expected character
  always @(posedge clk) begin
    char_beat_t exp_beat;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character 0x%02h (last %0b)", out_char_code, out_last_char);
        err_count++;
      end else begin
        exp_beat = expected_chars.pop_front();
        chars_checked++;
        if (out_char_code !== exp_beat.code) begin
          $error("out_char_code mismatch: expected 0x%02h, got 0x%02h",
                 exp_beat.code, out_char_code);
          err_count++;
        end
        if (out_last_char !== exp_beat.last) begin
          $error("out_last_char mismatch: expected %0b, got %0b",
                 exp_beat.last, out_last_char);
          err_count++;
        end
        if (exp_beat.last) begin
          runs_checked++;
        end
      end
    end
  end

  // Predict the character run of one value and queue it
  function automatic void render_value(input logic [ifmt_pkg::ValueW-1:0] value,
                                       input logic [ifmt_pkg::CmdW-1:0] mode);
    ifmt_pkg::char_t run[$];
    logic [3:0]      nib;
    logic [3:0]      digits[10];
    logic [31:0]     rest;
    logic            started;
    char_beat_t      beat;
    case (mode)
      ifmt_pkg::MODE_BIN: begin
        run.push_back(ifmt_pkg::CH_ZERO);
        run.push_back(ifmt_pkg::CH_B);
        for (int i = 0; i < 32; i++) begin
          if (i % 4 == 0) begin
            run.push_back(ifmt_pkg::CH_SPACE);
          end
          run.push_back(value[31 - i] ? CH_ONE : ifmt_pkg::CH_ZERO);
        end
      end
      ifmt_pkg::MODE_HEX: begin
        run.push_back(ifmt_pkg::CH_ZERO);
        run.push_back(ifmt_pkg::CH_X);
        for (int i = 7; i >= 0; i--) begin
          nib = value[4*i +: 4];
          run.push_back(nib < 4'd10 ? ifmt_pkg::CH_ZERO + nib
                                    : CH_UPPER_A + (nib - 4'd10));
        end
      end
      ifmt_pkg::MODE_DEC: begin
        rest = value;
        for (int i = 9; i >= 0; i--) begin
          digits[i] = 4'(rest % 10);
          rest = rest / 10;
        end
        started = 1'b0;
        for (int i = 0; i < 10; i++) begin
          if (digits[i] != 0 || started) begin
            started = 1'b1;
            run.push_back(ifmt_pkg::CH_ZERO + digits[i]);
          end
        end
        if (!started) begin
          run.push_back(ifmt_pkg::CH_ZERO);
        end
      end
      default: begin
        run.push_back(value[7:0]);
      end
    endcase
    foreach (run[i]) begin
      beat.code = run[i];
      beat.last = (i == run.size() - 1);
      expected_chars.push_back(beat);
    end
  endfunction

  // Offer one value; returns in the step of its transfer with valid still high
  task automatic send_value(input logic [ifmt_pkg::ValueW-1:0] value,
                            input logic [ifmt_pkg::CmdW-1:0] mode);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_value   <= value;
    in_command <= mode;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    render_value(value, mode);
    mode_count[mode]++;
  endtask

  // Drop valid after the last transfer of a burst
  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_gap_pct   = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Raw mode: low byte passes through, printable or not
  task automatic test_raw_bytes();
    send_value(32'h0000_0000, ifmt_pkg::MODE_RAW);
    send_value(32'hFFFF_FFFF, ifmt_pkg::MODE_RAW);
    send_value(32'h1234_567F, ifmt_pkg::MODE_RAW);
    send_value(32'hDEAD_BE80, ifmt_pkg::MODE_RAW);
    stop_sending();
  endtask

  // Binary mode: all-zero, all-one, alternating and end-bits-only patterns
  task automatic test_binary_digits();
    send_value(32'h0000_0000, ifmt_pkg::MODE_BIN);
    send_value(32'hFFFF_FFFF, ifmt_pkg::MODE_BIN);
    send_value(32'hA5A5_5A5A, ifmt_pkg::MODE_BIN);
    send_value(32'h8000_0001, ifmt_pkg::MODE_BIN);
    stop_sending();
  endtask

  // Hex mode: every nibble value, uppercase letters
  task automatic test_hex_digits();
    send_value(32'h0000_0000, ifmt_pkg::MODE_HEX);
    send_value(32'hFFFF_FFFF, ifmt_pkg::MODE_HEX);
    send_value(32'h0123_4567, ifmt_pkg::MODE_HEX);
    send_value(32'h89AB_CDEF, ifmt_pkg::MODE_HEX);
    stop_sending();
  endtask

  // Decimal mode: zero, short runs, the ten-digit boundary and the maximum
  task automatic test_decimal_digits();
    send_value(32'd0, ifmt_pkg::MODE_DEC);
    send_value(32'd1, ifmt_pkg::MODE_DEC);
    send_value(32'd10, ifmt_pkg::MODE_DEC);
    send_value(32'd999999999, ifmt_pkg::MODE_DEC);
    send_value(32'd1000000000, ifmt_pkg::MODE_DEC);
    send_value(32'd4000000000, ifmt_pkg::MODE_DEC);
    send_value(32'hFFFF_FFFF, ifmt_pkg::MODE_DEC);
    send_value(32'd1000000001, ifmt_pkg::MODE_DEC);
    stop_sending();
  endtask

  // Random values and modes; values spread over all run lengths
  task automatic test_random_mix(input int count);
    logic [ifmt_pkg::ValueW-1:0] value;
    logic [ifmt_pkg::CmdW-1:0]   mode;
    for (int n = 0; n < count; n++) begin
      mode = 2'($urandom_range(3));
      case ($urandom_range(3))
        0: value = $urandom;
        1: value = $urandom_range(0, 999);
        2: value = $urandom >> $urandom_range(31);
        default: value = ~($urandom_range(255) << $urandom_range(24));
      endcase
      send_value(value, mode);
    end
    stop_sending();
  endtask

  // Receiver stops for a long stretch while values keep coming
  task automatic test_output_backpressure();
    hold_req <= 1'b1;
    @(posedge clk);
    while (hold_left == 0) begin
      @(posedge clk);
    end
    hold_req <= 1'b0;
    for (int n = 0; n < 10; n++) begin
      send_value($urandom, (n % 2 == 0) ? ifmt_pkg::MODE_BIN : ifmt_pkg::MODE_DEC);
    end
    stop_sending();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(14, 84);
    test_raw_bytes();
    test_binary_digits();
    test_hex_digits();
    test_decimal_digits();
    test_random_mix(45);

    set_idling(84, 14);
    test_random_mix(45);

    set_idling(0, 0);
    test_output_backpressure();
    test_random_mix(40);

    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("values sent: %0d raw, %0d binary, %0d hex, %0d decimal",
             mode_count[ifmt_pkg::MODE_RAW], mode_count[ifmt_pkg::MODE_BIN],
             mode_count[ifmt_pkg::MODE_HEX], mode_count[ifmt_pkg::MODE_DEC]);
    $display("%0d characters in %0d runs checked, with idle gaps and a long output stall",
             chars_checked, runs_checked);
    if (err_count == 0) begin
      $display("integer_to_ascii_formatter_tb: PASS");
    end else begin
      $display("integer_to_ascii_formatter_tb: FAIL");
    end
    $finish;
  end

endmodule
